// File: rtl/tfcm_pkg.sv
// Shared types and constants for the thermal false-color palette pipeline.
package tfcm_pkg;

   localparam int TEMP_W    = 16;            // temperature and bound width
   localparam int DIFF_W    = TEMP_W + 1;    // signed differences against the low bound
   localparam int RATIO_W   = 16;            // unsigned Q0.16 ratio
   localparam int CHAN_W    = 8;             // one color byte
   localparam int GAIN_W    = 15;
   localparam int PROD_W    = 31;            // 25500 * ratio
   localparam int NUM_SHIFT = 16;
   localparam int NUM_W     = 14;            // scaled numerator, below 8700
   localparam int RECIP_W   = 11;
   localparam int RECIP_SHIFT = 16;
   localparam int EST_W     = 9;             // quotient estimate before correction
   localparam int DIVISOR_W = 6;

   localparam int DIV_STEPS = RATIO_W;       // one quotient bit per stage
   localparam int LATENCY   = DIV_STEPS + 6; // edges from accept to result strobe

   localparam logic [TEMP_W-1:0] LOW_TEMP_RESET  = 16'd0;
   localparam logic [TEMP_W-1:0] HIGH_TEMP_RESET = 16'd2560;

   localparam logic [RATIO_W-1:0] RATIO_ZERO  = 16'd0;
   localparam logic [RATIO_W-1:0] RATIO_MAX   = 16'hFFFF;
   localparam logic [RATIO_W-1:0] BREAK_HIGH  = 16'd43254;
   localparam logic [RATIO_W-1:0] BREAK_LOW   = 16'd21627;

   localparam logic [GAIN_W-1:0] PAL_GAIN     = 15'd25500;
   // 255 * 33 * 65536 and 255 * 100 * 65536
   localparam logic [PROD_W-1:0] MID_OFFSET   = 31'd551485440;
   localparam logic [PROD_W-1:0] HIGH_OFFSET  = 31'd1671168000;

   // floor(65536 / d); the estimate is then exact or one short
   localparam logic [RECIP_W-1:0]   RECIP_33   = 11'd1985;
   localparam logic [RECIP_W-1:0]   RECIP_34   = 11'd1927;
   localparam logic [DIVISOR_W-1:0] DIVISOR_33 = 6'd33;
   localparam logic [DIVISOR_W-1:0] DIVISOR_34 = 6'd34;

   localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;
   localparam logic [CHAN_W-1:0] CHAN_NONE = 8'h00;

   typedef enum logic [1:0] {
      RSEL_QUOT,
      RSEL_ZERO,
      RSEL_MAX
   } rsel_type;

   typedef enum logic [1:0] {
      BAND_LOW,
      BAND_MID,
      BAND_HIGH
   } band_type;

   typedef enum logic {
      CSR_LOW_TEMPERATURE  = 1'b0,
      CSR_HIGH_TEMPERATURE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic     valid;
      rsel_type rsel;
      logic     clamped;
   } ctl_type;

endpackage

// File: rtl/tfcm_front.sv
// Front stages: offsets against the low bound, range checks and ratio override code.
module tfcm_front
   import tfcm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [TEMP_W-1:0]   temperature,
   input  logic [TEMP_W-1:0]   low_temperature,
   input  logic [TEMP_W-1:0]   high_temperature,
   output ctl_type             ctl_out,
   output logic [RATIO_W-1:0]  rem_out,
   output logic [RATIO_W-1:0]  span_out
);

   logic              valid_a_ff, valid_a_in;
   logic [DIFF_W-1:0] diff_a_ff, diff_a_in;
   logic [DIFF_W-1:0] span_a_ff, span_a_in;

   ctl_type            ctl_b_ff, ctl_b_in;
   logic [RATIO_W-1:0] rem_b_ff, rem_b_in;
   logic [RATIO_W-1:0] span_b_ff, span_b_in;

   always_comb begin
      valid_a_in = accept;
      diff_a_in  = {temperature[TEMP_W-1], temperature}
                 - {low_temperature[TEMP_W-1], low_temperature};
      span_a_in  = {high_temperature[TEMP_W-1], high_temperature}
                 - {low_temperature[TEMP_W-1], low_temperature};
   end

   always_comb begin
      ctl_b_in.valid = valid_a_ff;
      priority if ($signed(span_a_ff) <= $signed(DIFF_W'(0))) begin
         ctl_b_in.rsel    = RSEL_ZERO;
         ctl_b_in.clamped = 1'b1;
      end else if ($signed(diff_a_ff) < $signed(DIFF_W'(0))) begin
         ctl_b_in.rsel    = RSEL_ZERO;
         ctl_b_in.clamped = 1'b1;
      end else if ($signed(diff_a_ff) > $signed(span_a_ff)) begin
         ctl_b_in.rsel    = RSEL_MAX;
         ctl_b_in.clamped = 1'b1;
      end else if (diff_a_ff == span_a_ff) begin
         // ratio of exactly one does not fit Q0.16
         ctl_b_in.rsel    = RSEL_MAX;
         ctl_b_in.clamped = 1'b0;
      end else begin
         ctl_b_in.rsel    = RSEL_QUOT;
         ctl_b_in.clamped = 1'b0;
      end
      rem_b_in  = diff_a_ff[RATIO_W-1:0];
      span_b_in = span_a_ff[RATIO_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         ctl_b_ff   <= '0;
      end else begin
         valid_a_ff <= valid_a_in;
         ctl_b_ff   <= ctl_b_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_a_ff <= diff_a_in;
      span_a_ff <= span_a_in;
      rem_b_ff  <= rem_b_in;
      span_b_ff <= span_b_in;
   end

   assign ctl_out  = ctl_b_ff;
   assign rem_out  = rem_b_ff;
   assign span_out = span_b_ff;

endmodule

// File: rtl/tfcm_div_step.sv
// One restoring division stage: one quotient bit of the Q0.16 ratio per clock.
module tfcm_div_step
   import tfcm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_type             ctl_i,
   input  logic [RATIO_W-1:0]  rem_i,
   input  logic [RATIO_W-1:0]  quot_i,
   input  logic [RATIO_W-1:0]  span_i,
   output ctl_type             ctl_o,
   output logic [RATIO_W-1:0]  rem_o,
   output logic [RATIO_W-1:0]  quot_o,
   output logic [RATIO_W-1:0]  span_o
);

   ctl_type            ctl_ff, ctl_in;
   logic [RATIO_W-1:0] rem_ff, rem_in;
   logic [RATIO_W-1:0] quot_ff, quot_in;
   logic [RATIO_W-1:0] span_ff, span_in;

   logic [RATIO_W:0] twice;
   logic [RATIO_W:0] trial;
   logic             fits;

   always_comb begin
      twice   = {rem_i, 1'b0};
      trial   = twice - {1'b0, span_i};
      fits    = (twice >= {1'b0, span_i});
      ctl_in  = ctl_i;
      rem_in  = fits ? trial[RATIO_W-1:0] : twice[RATIO_W-1:0];
      quot_in = {quot_i[RATIO_W-2:0], fits};
      span_in = span_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      span_ff <= span_in;
   end

   assign ctl_o  = ctl_ff;
   assign rem_o  = rem_ff;
   assign quot_o = quot_ff;
   assign span_o = span_ff;

endmodule

// File: rtl/tfcm_palette.sv
// Palette stages: ratio override, band scaling and division of the bytes by 33 or 34.
module tfcm_palette
   import tfcm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_type             ctl_i,
   input  logic [RATIO_W-1:0]  quot_i,
   output logic                strobe,
   output logic [CHAN_W-1:0]   blue,
   output logic [CHAN_W-1:0]   green,
   output logic [CHAN_W-1:0]   red,
   output logic                clamped
);

   // stage 1: final ratio, band and 25500 * ratio
   logic               valid_1_ff, valid_1_in;
   logic               clamp_1_ff, clamp_1_in;
   band_type           band_1_ff, band_1_in;
   logic [PROD_W-1:0]  prod_1_ff, prod_1_in;
   logic [RATIO_W-1:0] ratio;

   // stage 2: numerators scaled down by 2^16
   logic               valid_2_ff, valid_2_in;
   logic               clamp_2_ff, clamp_2_in;
   band_type           band_2_ff, band_2_in;
   logic [NUM_W-1:0]   num_a_2_ff, num_a_2_in;
   logic [NUM_W-1:0]   num_b_2_ff, num_b_2_in;
   logic [PROD_W-1:0]  full_a, full_b;

   // stage 3: reciprocal estimates
   logic               valid_3_ff, valid_3_in;
   logic               clamp_3_ff, clamp_3_in;
   band_type           band_3_ff, band_3_in;
   logic [NUM_W-1:0]   num_a_3_ff, num_a_3_in;
   logic [NUM_W-1:0]   num_b_3_ff, num_b_3_in;
   logic [EST_W-1:0]   est_a_3_ff, est_a_3_in;
   logic [EST_W-1:0]   est_b_3_ff, est_b_3_in;
   logic [RECIP_W-1:0] recip_a;
   logic [NUM_W+RECIP_W-1:0] scaled_a, scaled_b;

   // stage 4: correction and byte selection
   logic               valid_4_ff, valid_4_in;
   logic               clamp_4_ff, clamp_4_in;
   logic [CHAN_W-1:0]  blue_4_ff, blue_4_in;
   logic [CHAN_W-1:0]  green_4_ff, green_4_in;
   logic [CHAN_W-1:0]  red_4_ff, red_4_in;
   logic [DIVISOR_W-1:0] div_a;
   logic [NUM_W:0]     rem_a, rem_b;
   logic [EST_W-1:0]   quo_a, quo_b;

   always_comb begin
      unique case (ctl_i.rsel)
         RSEL_QUOT: ratio = quot_i;
         RSEL_ZERO: ratio = RATIO_ZERO;
         RSEL_MAX:  ratio = RATIO_MAX;
         default:   ratio = RATIO_ZERO;
      endcase
      valid_1_in = ctl_i.valid;
      clamp_1_in = ctl_i.clamped;
      priority if (ratio >= BREAK_HIGH) begin
         band_1_in = BAND_HIGH;
      end else if (ratio >= BREAK_LOW) begin
         band_1_in = BAND_MID;
      end else begin
         band_1_in = BAND_LOW;
      end
      prod_1_in = PROD_W'(ratio) * PROD_W'(PAL_GAIN);
   end

   always_comb begin
      valid_2_in = valid_1_ff;
      clamp_2_in = clamp_1_ff;
      band_2_in  = band_1_ff;
      unique case (band_1_ff)
         BAND_HIGH: full_a = HIGH_OFFSET - prod_1_ff;
         BAND_MID:  full_a = prod_1_ff - MID_OFFSET;
         BAND_LOW:  full_a = prod_1_ff;
         default:   full_a = prod_1_ff;
      endcase
      full_b     = MID_OFFSET - prod_1_ff;
      num_a_2_in = full_a[NUM_SHIFT +: NUM_W];
      num_b_2_in = full_b[NUM_SHIFT +: NUM_W];
   end

   always_comb begin
      valid_3_in = valid_2_ff;
      clamp_3_in = clamp_2_ff;
      band_3_in  = band_2_ff;
      num_a_3_in = num_a_2_ff;
      num_b_3_in = num_b_2_ff;
      recip_a    = (band_2_ff == BAND_HIGH) ? RECIP_34 : RECIP_33;
      scaled_a   = (NUM_W+RECIP_W)'(num_a_2_ff) * (NUM_W+RECIP_W)'(recip_a);
      scaled_b   = (NUM_W+RECIP_W)'(num_b_2_ff) * (NUM_W+RECIP_W)'(RECIP_33);
      est_a_3_in = scaled_a[RECIP_SHIFT +: EST_W];
      est_b_3_in = scaled_b[RECIP_SHIFT +: EST_W];
   end

   always_comb begin
      valid_4_in = valid_3_ff;
      clamp_4_in = clamp_3_ff;
      div_a      = (band_3_ff == BAND_HIGH) ? DIVISOR_34 : DIVISOR_33;
      rem_a      = {1'b0, num_a_3_ff}
                 - (NUM_W+1)'(div_a) * (NUM_W+1)'(est_a_3_ff);
      rem_b      = {1'b0, num_b_3_ff}
                 - (NUM_W+1)'(DIVISOR_33) * (NUM_W+1)'(est_b_3_ff);
      // estimate is at most one short
      quo_a      = est_a_3_ff + EST_W'(rem_a >= (NUM_W+1)'(div_a));
      quo_b      = est_b_3_ff + EST_W'(rem_b >= (NUM_W+1)'(DIVISOR_33));
      unique case (band_3_ff)
         BAND_HIGH: begin
            red_4_in   = CHAN_FULL;
            green_4_in = quo_a[CHAN_W-1:0];
            blue_4_in  = quo_a[CHAN_W-1:0];
         end
         BAND_MID: begin
            red_4_in   = CHAN_FULL;
            green_4_in = quo_a[CHAN_W-1:0];
            blue_4_in  = CHAN_NONE;
         end
         BAND_LOW: begin
            red_4_in   = quo_a[CHAN_W-1:0];
            green_4_in = CHAN_FULL;
            blue_4_in  = quo_b[CHAN_W-1:0];
         end
         default: begin
            red_4_in   = CHAN_NONE;
            green_4_in = CHAN_NONE;
            blue_4_in  = CHAN_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_1_ff <= 1'b0;
         valid_2_ff <= 1'b0;
         valid_3_ff <= 1'b0;
         valid_4_ff <= 1'b0;
      end else begin
         valid_1_ff <= valid_1_in;
         valid_2_ff <= valid_2_in;
         valid_3_ff <= valid_3_in;
         valid_4_ff <= valid_4_in;
      end
   end

   always_ff @(posedge clock) begin
      clamp_1_ff <= clamp_1_in;
      band_1_ff  <= band_1_in;
      prod_1_ff  <= prod_1_in;
      clamp_2_ff <= clamp_2_in;
      band_2_ff  <= band_2_in;
      num_a_2_ff <= num_a_2_in;
      num_b_2_ff <= num_b_2_in;
      clamp_3_ff <= clamp_3_in;
      band_3_ff  <= band_3_in;
      num_a_3_ff <= num_a_3_in;
      num_b_3_ff <= num_b_3_in;
      est_a_3_ff <= est_a_3_in;
      est_b_3_ff <= est_b_3_in;
      clamp_4_ff <= clamp_4_in;
      blue_4_ff  <= blue_4_in;
      green_4_ff <= green_4_in;
      red_4_ff   <= red_4_in;
   end

   assign strobe  = valid_4_ff;
   assign blue    = blue_4_ff;
   assign green   = green_4_ff;
   assign red     = red_4_ff;
   assign clamped = clamp_4_ff;

endmodule

// File: rtl/thermal_false_color_map_top.sv
// Top level of the thermal false-color palette: bound registers and the pixel pipeline.
//
//  channel   ports                                   handshake
//  -------   -------------------------------------   -------------------------------
//  request   start, busy, req_temperature            taken when start and not busy
//  result    rsp_strobe, rsp_blue/green/red/clamped  one-cycle strobe, no back-pressure
//  config    csr_write_enable, csr_index, csr_write_data   written at the edge, no read-back
//
//  One item enters per cycle; busy is always low.
//  Each result strobes once its item has passed two front stages, sixteen divider
//  stages (one ratio bit each) and four palette stages.
//  Synchronous reset clears the valid chain and loads the bound registers
//  with 0 and 2560.
//  No stalls: the result side cannot hold the pipeline off.
module thermal_false_color_map_top
   import tfcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [TEMP_W-1:0]  req_temperature,
   output logic               rsp_strobe,
   output logic [CHAN_W-1:0]  rsp_blue,
   output logic [CHAN_W-1:0]  rsp_green,
   output logic [CHAN_W-1:0]  rsp_red,
   output logic               rsp_clamped,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [TEMP_W-1:0]  csr_write_data
);

   logic [TEMP_W-1:0] low_temp_ff, low_temp_in;
   logic [TEMP_W-1:0] high_temp_ff, high_temp_in;
   logic              accept;

   ctl_type            ctl_chain  [DIV_STEPS+1];
   logic [RATIO_W-1:0] rem_chain  [DIV_STEPS+1];
   logic [RATIO_W-1:0] quot_chain [DIV_STEPS+1];
   logic [RATIO_W-1:0] span_chain [DIV_STEPS+1];

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_comb begin
      low_temp_in  = low_temp_ff;
      high_temp_in = high_temp_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOW_TEMPERATURE:  low_temp_in  = csr_write_data;
            CSR_HIGH_TEMPERATURE: high_temp_in = csr_write_data;
            default:              low_temp_in  = low_temp_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_temp_ff  <= LOW_TEMP_RESET;
         high_temp_ff <= HIGH_TEMP_RESET;
      end else begin
         low_temp_ff  <= low_temp_in;
         high_temp_ff <= high_temp_in;
      end
   end

   tfcm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .temperature      (req_temperature),
      .low_temperature  (low_temp_ff),
      .high_temperature (high_temp_ff),
      .ctl_out          (ctl_chain[0]),
      .rem_out          (rem_chain[0]),
      .span_out         (span_chain[0])
   );

   assign quot_chain[0] = RATIO_ZERO;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      tfcm_div_step u_step (
         .clock  (clock),
         .reset  (reset),
         .ctl_i  (ctl_chain[i]),
         .rem_i  (rem_chain[i]),
         .quot_i (quot_chain[i]),
         .span_i (span_chain[i]),
         .ctl_o  (ctl_chain[i+1]),
         .rem_o  (rem_chain[i+1]),
         .quot_o (quot_chain[i+1]),
         .span_o (span_chain[i+1])
      );
   end

   tfcm_palette u_palette (
      .clock   (clock),
      .reset   (reset),
      .ctl_i   (ctl_chain[DIV_STEPS]),
      .quot_i  (quot_chain[DIV_STEPS]),
      .strobe  (rsp_strobe),
      .blue    (rsp_blue),
      .green   (rsp_green),
      .red     (rsp_red),
      .clamped (rsp_clamped)
   );

   // every taken item comes out after the fixed pipeline depth
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("result strobe missing after pipeline latency");

   // outside the top two bands green is full
   a_low_band_green: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_red != CHAN_FULL) |-> rsp_green == CHAN_FULL)
      else $error("low band result without full green");

   // upper bands: blue is off or tracks green
   a_upper_blue: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_red == CHAN_FULL) |->
         (rsp_blue == CHAN_NONE || rsp_blue == rsp_green))
      else $error("upper band blue inconsistent");

   // low band red and blue are truncations of complementary values
   a_low_band_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_red != CHAN_FULL) |->
         ({1'b0, rsp_red} + {1'b0, rsp_blue}) >= (CHAN_W+1)'(254))
      else $error("low band red plus blue out of range");

endmodule

// File: bench/tfcm_checker.sv
// Checker for the false-color palette: tracks the bounds, predicts each pixel color, compares.
`timescale 1ns / 1ps

module tfcm_checker
   import tfcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [TEMP_W-1:0]  req_temperature,
   input  logic               rsp_strobe,
   input  logic [CHAN_W-1:0]  rsp_blue,
   input  logic [CHAN_W-1:0]  rsp_green,
   input  logic [CHAN_W-1:0]  rsp_red,
   input  logic               rsp_clamped,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [TEMP_W-1:0]  csr_write_data,
   output int                 error_count,
   output int                 pending_count,
   output int                 checked_count,
   output int                 clamped_count
);

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       clamped;
   } pixel_color_type;

   localparam logic [63:0] FRAC_ONE   = 64'd65536;
   localparam logic [63:0] FRAC_MAX   = 64'd65535;
   localparam logic [63:0] KNEE_UPPER = 64'd43254;   // 0.66 in Q0.16, rounded up
   localparam logic [63:0] KNEE_LOWER = 64'd21627;   // 0.33 in Q0.16, rounded up

   logic signed [15:0] low_bound;
   logic signed [15:0] high_bound;
   pixel_color_type    expected_colors[$];

   function automatic pixel_color_type palette_color(input logic signed [15:0] temp,
                                                     input logic signed [15:0] lo,
                                                     input logic signed [15:0] hi);
      int              span;
      int              offset;
      logic [63:0]     ratio;
      logic [63:0]     level;
      pixel_color_type px;
      span = int'(hi) - int'(lo);
      offset = int'(temp) - int'(lo);
      px.clamped = 1'b0;
      if (span <= 0) begin
         ratio = 64'd0;
         px.clamped = 1'b1;
      end else if (offset < 0) begin
         ratio = 64'd0;
         px.clamped = 1'b1;
      end else if (offset > span) begin
         ratio = FRAC_MAX;
         px.clamped = 1'b1;
      end else begin
         ratio = (64'(offset) * FRAC_ONE) / 64'(span);
         // a pixel exactly at the upper bound gives ratio one, which does not fit
         if (ratio > FRAC_MAX) ratio = FRAC_MAX;
      end
      if (ratio >= KNEE_UPPER) begin
         level = (64'd255 * (64'd100 * FRAC_ONE - 64'd100 * ratio)) / (64'd34 * FRAC_ONE);
         px.red = 8'hFF;
         px.green = level[7:0];
         px.blue = level[7:0];
      end else if (ratio >= KNEE_LOWER) begin
         level = (64'd255 * (64'd100 * ratio - 64'd33 * FRAC_ONE)) / (64'd33 * FRAC_ONE);
         px.red = 8'hFF;
         px.green = level[7:0];
         px.blue = 8'h00;
      end else begin
         level = (64'd25500 * ratio) / (64'd33 * FRAC_ONE);
         px.red = level[7:0];
         px.green = 8'hFF;
         level = (64'd255 * (64'd33 * FRAC_ONE - 64'd100 * ratio)) / (64'd33 * FRAC_ONE);
         px.blue = level[7:0];
      end
      return px;
   endfunction

   initial begin
      error_count = 0;
      pending_count = 0;
      checked_count = 0;
      clamped_count = 0;
      low_bound = LOW_TEMP_RESET;
      high_bound = HIGH_TEMP_RESET;
   end

   always @(posedge clock) begin
      pixel_color_type want;
      if (reset) begin
         low_bound = LOW_TEMP_RESET;
         high_bound = HIGH_TEMP_RESET;
         expected_colors.delete();
      end else begin
         // results at this edge belong to items taken earlier, so compare first
         if (rsp_strobe) begin
            if (expected_colors.size() == 0) begin
               $display("%0t: result with no item outstanding: b=%h g=%h r=%h c=%b", $time,
                        rsp_blue, rsp_green, rsp_red, rsp_clamped);
               error_count++;
            end else begin
               want = expected_colors.pop_front();
               checked_count++;
               if (want.clamped) clamped_count++;
               if (rsp_blue !== want.blue) begin
                  $display("%0t: blue expected %h actual %h", $time, want.blue, rsp_blue);
                  error_count++;
               end
               if (rsp_green !== want.green) begin
                  $display("%0t: green expected %h actual %h", $time, want.green, rsp_green);
                  error_count++;
               end
               if (rsp_red !== want.red) begin
                  $display("%0t: red expected %h actual %h", $time, want.red, rsp_red);
                  error_count++;
               end
               if (rsp_clamped !== want.clamped) begin
                  $display("%0t: clamped expected %b actual %b", $time, want.clamped,
                           rsp_clamped);
                  error_count++;
               end
            end
         end
         if (start && !busy)
            expected_colors.push_back(palette_color(req_temperature, low_bound, high_bound));
         if (csr_write_enable) begin
            if (csr_index == CSR_LOW_TEMPERATURE)
               low_bound = csr_write_data;
            else
               high_bound = csr_write_data;
         end
      end
      pending_count = expected_colors.size();
   end

endmodule

// File: bench/thermal_false_color_map_top_test.sv
// Testbench top for the false-color palette: clock, reset, bound settings, pixel stimulus, verdict.
`timescale 1ns / 1ps

module thermal_false_color_map_top_test;
   import tfcm_pkg::*;

   localparam int FIXED_SETTINGS  = 8;
   localparam int RANDOM_SETTINGS = 4;
   localparam int ITEMS_PER_SETTING = 40;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [TEMP_W-1:0]  req_temperature;
   logic               rsp_strobe;
   logic [CHAN_W-1:0]  rsp_blue;
   logic [CHAN_W-1:0]  rsp_green;
   logic [CHAN_W-1:0]  rsp_red;
   logic               rsp_clamped;
   logic               csr_write_enable;
   logic               csr_index;
   logic [TEMP_W-1:0]  csr_write_data;

   int error_count;
   int pending_count;
   int checked_count;
   int clamped_count;
   int items_sent;
   int settings_run;

   logic signed [15:0] fixed_low[FIXED_SETTINGS];
   logic signed [15:0] fixed_high[FIXED_SETTINGS];
   logic signed [15:0] opening_pixels[$];

   thermal_false_color_map_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_temperature (req_temperature),
      .rsp_strobe      (rsp_strobe),
      .rsp_blue        (rsp_blue),
      .rsp_green       (rsp_green),
      .rsp_red         (rsp_red),
      .rsp_clamped     (rsp_clamped),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   tfcm_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_temperature (req_temperature),
      .rsp_strobe      (rsp_strobe),
      .rsp_blue        (rsp_blue),
      .rsp_green       (rsp_green),
      .rsp_red         (rsp_red),
      .rsp_clamped     (rsp_clamped),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .error_count     (error_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count),
      .clamped_count   (clamped_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #2000000;
      $display("thermal_false_color_map_top_test: errors");
      $finish;
   end

   // hold start high across back-to-back items; the caller drops it in gaps
   task automatic send_pixel(input logic [15:0] temp);
      @(negedge clock);
      start <= 1'b1;
      req_temperature <= temp;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic idle_cycles(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start <= 1'b0;
         req_temperature <= 16'($urandom_range(0, 65535));
      end
   endtask

   function automatic int pick_gap(input bit burst);
      int roll;
      roll = $urandom_range(0, 99);
      if (burst || roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] pick_temperature(input logic signed [15:0] lo,
                                                    input logic signed [15:0] hi);
      int span;
      int roll;
      span = int'(hi) - int'(lo);
      roll = $urandom_range(0, 99);
      if (span > 0 && roll < 70)
         return 16'(int'(lo) + int'($urandom_range(0, span)));
      if (roll < 85) begin
         case ($urandom_range(0, 4))
            0: return lo;
            1: return hi;
            2: return 16'(int'(lo) - 1);
            3: return 16'(int'(hi) + 1);
            default: return 16'(int'(lo) + span / 3);
         endcase
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic write_bounds(input logic signed [15:0] lo, input logic signed [15:0] hi);
      @(negedge clock);
      start <= 1'b0;
      csr_write_enable <= 1'b1;
      csr_index <= CSR_LOW_TEMPERATURE;
      csr_write_data <= lo;
      @(negedge clock);
      csr_index <= CSR_HIGH_TEMPERATURE;
      csr_write_data <= hi;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_write_data <= 16'($urandom_range(0, 65535));
      settings_run++;
   endtask

   // drain the pipe before touching the bounds again
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic run_random_pixels(input logic signed [15:0] lo, input logic signed [15:0] hi,
                                    input int count);
      bit burst;
      burst = ($urandom_range(0, 3) == 0);
      repeat (count) begin
         send_pixel(pick_temperature(lo, hi));
         idle_cycles(pick_gap(burst));
      end
   endtask

   initial begin
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      int                 span;
      reset = 1'b1;
      start = 1'b0;
      req_temperature = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_LOW_TEMPERATURE;
      csr_write_data = '0;
      items_sent = 0;
      settings_run = 0;

      fixed_low  = '{16'sd0,      -16'sd32768, 16'sd100, 16'sd32767,  -16'sd32768,
                     16'sd32766,  -16'sd640,   16'sd0};
      fixed_high = '{16'sd2560,   16'sd32767,  16'sd100, -16'sd32768, -16'sd32767,
                     16'sd32767,  16'sd640,    16'sd3};

      // extremes, both range edges and both sides of each palette knee at span 2560
      opening_pixels = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, 16'sd2560,
                         16'sd2561, 16'sd2559, 16'sd844, 16'sd845, 16'sd1689, 16'sd1690,
                         16'sd1280, 16'sh5555, -16'sh5556, 16'sd2000};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int s = 0; s < FIXED_SETTINGS + RANDOM_SETTINGS; s++) begin
         if (s < FIXED_SETTINGS) begin
            lo = fixed_low[s];
            hi = fixed_high[s];
         end else begin
            lo = 16'($urandom_range(0, 65535));
            case ($urandom_range(0, 3))
               0: span = $urandom_range(1, 64);
               1: span = $urandom_range(65, 4096);
               2: span = $urandom_range(4097, 65535);
               default: span = -int'($urandom_range(0, 300));
            endcase
            hi = (int'(lo) + span > 32767) ? 16'sd32767 : 16'(int'(lo) + span);
         end
         write_bounds(lo, hi);
         if (s == 0) begin
            foreach (opening_pixels[k]) begin
               send_pixel(opening_pixels[k]);
               idle_cycles(pick_gap(1'b0));
            end
         end
         run_random_pixels(lo, hi, ITEMS_PER_SETTING);
         wait_drained();
      end

      repeat (LATENCY + 10) @(negedge clock);

      $display("%0d pixels over %0d bound settings; %0d colors checked, %0d of them clamped",
               items_sent, settings_run, checked_count, clamped_count);
      if (error_count == 0 && pending_count == 0)
         $display("thermal_false_color_map_top_test: clean");
      else
         $display("thermal_false_color_map_top_test: errors");
      $finish;
   end

endmodule
